FILE: design/hba_pkg.sv
// shared types and constants for the hierarchical bitmap id allocator
// operation codes, controller command and datapath status structs
// no dependencies
package hba_pkg;

   localparam int LEVELS_DEF    = 3;
   localparam int WORD_BITS_DEF = 64;
   localparam int ID_W          = 18;
   localparam int OP_W          = 2;
   localparam int LVL_W         = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC_ANY = 2'd0,
      OP_ALLOC_ID  = 2'd1,
      OP_FREE      = 2'd2,
      OP_QUERY     = 2'd3
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             clr_step;
      logic             rd_en;
      logic             cap;
      logic             wr_en;
      logic             rsp_load;
      logic             rsp_ok;
      logic [LVL_W-1:0] lvl;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   word_zero;
      logic   leaf_free;
      logic   prop;
      logic   clr_done;
      logic   rsp_free;
   } stat_type;

endpackage

FILE: design/hba_if.sv
// request and response channel interfaces of the id allocator
// depends on hba_pkg
interface hba_req_if;
   logic                     valid;
   logic                     ready;
   logic [hba_pkg::OP_W-1:0] op;
   logic [hba_pkg::ID_W-1:0] id;

   modport source  (output valid, op, id, input ready);
   modport sink    (input valid, op, id, output ready);
   modport monitor (input valid, ready, op, id);
endinterface

interface hba_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [hba_pkg::ID_W-1:0] result_id;
   logic                     ok;

   modport source  (output valid, result_id, ok, input ready);
   modport sink    (input valid, result_id, ok, output ready);
   modport monitor (input valid, ready, result_id, ok);
endinterface

FILE: design/hba_datapath.sv
// datapath: per-level free map memories, path word registers, response register
// depends on hba_pkg
module hba_datapath #(
   parameter int LEVELS    = hba_pkg::LEVELS_DEF,
   parameter int WORD_BITS = hba_pkg::WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hba_pkg::cmd_type         cmd,
   output hba_pkg::stat_type        stat,
   input  logic [hba_pkg::OP_W-1:0] req_op,
   input  logic [hba_pkg::ID_W-1:0] req_id,
   output logic                     rsp_valid,
   output logic [hba_pkg::ID_W-1:0] rsp_result_id,
   output logic                     rsp_ok,
   input  logic                     rsp_ready
);
   import hba_pkg::*;

   localparam int LOG   = $clog2(WORD_BITS);
   localparam int IDW   = LEVELS * LOG;
   localparam int CLR_W = (LEVELS - 1) * LOG;
   localparam int LW    = $clog2(LEVELS);
   localparam int WIDE  = ID_W + IDW;

   op_type                 op_ff;
   logic [ID_W-1:0]        id_ff;
   logic [IDW-1:0]         tgt_ff;
   logic [WORD_BITS-1:0]   words_ff [LEVELS];
   logic [WORD_BITS-1:0]   rd_data  [LEVELS];
   logic [LOG-1:0]         dig      [LEVELS];
   logic [CLR_W-1:0]       clr_ff;
   logic                   rsp_valid_ff;
   logic [ID_W-1:0]        rsp_id_ff;
   logic                   rsp_ok_ff;

   logic [LW-1:0]          lvl;
   logic [WIDE-1:0]        wide_id;
   logic [WIDE-1:0]        wide_req;
   logic [WIDE-1:0]        wide_tgt;
   logic [WORD_BITS-1:0]   cur_word;
   logic [LOG-1:0]         lowest;
   logic [WORD_BITS-1:0]   old_word;
   logic [WORD_BITS-1:0]   new_word;
   logic [WORD_BITS-1:0]   bit_mask;
   logic                   take;

   assign lvl      = cmd.lvl[LW-1:0];
   assign wide_id  = {{IDW{1'b0}}, id_ff};
   assign wide_req = {{IDW{1'b0}}, req_id};
   assign wide_tgt = {{ID_W{1'b0}}, tgt_ff};
   assign cur_word = rd_data[lvl];
   assign old_word = words_ff[lvl];
   assign take     = (op_ff != OP_FREE);

   // digit of the target id at every level
   for (genvar lv = 0; lv < LEVELS; lv++) begin : g_dig
      assign dig[lv] = tgt_ff[(LEVELS-1-lv)*LOG +: LOG];
   end

   // lowest free bit of the word just read
   always_comb begin
      lowest = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cur_word[i]) begin
            lowest = LOG'(i);
         end
      end
   end

   // updated word on the way back up
   always_comb begin
      bit_mask = WORD_BITS'(1) << dig[lvl];
      new_word = take ? (old_word & ~bit_mask) : (old_word | bit_mask);
   end

   // operation capture and path walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_op);
         id_ff  <= req_id;
         tgt_ff <= (op_type'(req_op) == OP_ALLOC_ANY) ? '0 : wide_req[IDW-1:0];
      end else if (cmd.cap) begin
         words_ff[lvl] <= cur_word;
         if (op_ff == OP_ALLOC_ANY) begin
            tgt_ff <= {tgt_ff[IDW-LOG-1:0], lowest};
         end
      end
   end

   // top summary word
   logic [WORD_BITS-1:0] top_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '1;
      end else if (cmd.wr_en && lvl == '0) begin
         top_ff <= new_word;
      end
   end
   assign rd_data[0] = top_ff;

   // one memory for each level below the top
   for (genvar lv = 1; lv < LEVELS; lv++) begin : g_lvl
      localparam int AW = lv * LOG;
      logic [WORD_BITS-1:0] mem [1 << AW];
      logic [WORD_BITS-1:0] rdq_ff;
      logic [AW-1:0]        raddr;
      logic [AW-1:0]        waddr;

      assign raddr = (op_ff == OP_ALLOC_ANY) ? tgt_ff[AW-1:0] : tgt_ff[IDW-1 -: AW];
      assign waddr = tgt_ff[IDW-1 -: AW];

      always_ff @(posedge clock) begin
         if (cmd.clr_step) begin
            mem[clr_ff[AW-1:0]] <= '1;
         end else if (cmd.wr_en && lvl == LW'(lv)) begin
            mem[waddr] <= new_word;
         end
         if (cmd.rd_en) begin
            rdq_ff <= mem[raddr];
         end
      end
      assign rd_data[lv] = rdq_ff;
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_id_ff <= (op_ff == OP_ALLOC_ANY) ? wide_tgt[ID_W-1:0] : id_ff;
         rsp_ok_ff <= cmd.rsp_ok;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_ok        = rsp_ok_ff;

   // status back to the controller
   always_comb begin
      stat.op        = op_ff;
      stat.in_range  = (wide_id[WIDE-1:IDW] == '0);
      stat.word_zero = (cur_word == '0);
      stat.leaf_free = cur_word[tgt_ff[LOG-1:0]];
      stat.prop      = take ? (new_word == '0) : (old_word == '0);
      stat.clr_done  = (clr_ff == '1);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

FILE: design/hba_ctrl.sv
// controller: clearing pass, read walk down the tree, write walk up, response
// depends on hba_pkg
module hba_ctrl #(
   parameter int LEVELS = hba_pkg::LEVELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hba_pkg::stat_type stat,
   output hba_pkg::cmd_type  cmd
);
   import hba_pkg::*;

   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_RD    = 6'b000100,
      S_CAP   = 6'b001000,
      S_WR    = 6'b010000,
      S_RSP   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             ok_ff, ok_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         lvl_ff   <= '0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         ok_ff    <= ok_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      ok_in        = ok_ff;
      cmd          = '0;
      cmd.lvl      = lvl_ff;
      cmd.rsp_ok   = ok_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               lvl_in   = '0;
               ok_in    = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (stat.op != OP_ALLOC_ANY && !stat.in_range) begin
               state_in = S_RSP;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CAP;
            end
         end
         S_CAP: begin
            cmd.cap = 1'b1;
            if (stat.op == OP_ALLOC_ANY && lvl_ff == '0 && stat.word_zero) begin
               state_in = S_RSP;
            end else if (lvl_ff == LAST_LVL) begin
               case (stat.op)
                  OP_ALLOC_ANY: begin
                     ok_in    = 1'b1;
                     state_in = S_WR;
                  end
                  OP_ALLOC_ID: begin
                     ok_in    = stat.leaf_free;
                     state_in = stat.leaf_free ? S_WR : S_RSP;
                  end
                  OP_FREE: begin
                     ok_in    = !stat.leaf_free;
                     state_in = stat.leaf_free ? S_RSP : S_WR;
                  end
                  default: begin
                     ok_in    = !stat.leaf_free;
                     state_in = S_RSP;
                  end
               endcase
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_WR: begin
            cmd.wr_en = 1'b1;
            if (stat.prop && lvl_ff != '0) begin
               lvl_in = lvl_ff - 1'b1;
            end else begin
               state_in = S_RSP;
            end
         end
         S_RSP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: design/hierarchical_bitmap_id_allocator.sv
// top level of the hierarchical bitmap id allocator
// ties controller and datapath to the request and response channels
// depends on hba_pkg, hba_if, hba_ctrl, hba_datapath
//
//   channel | dir | payload          | transfer when
//   req     | in  | op, id           | valid && ready
//   rsp     | out | result_id, ok    | valid && ready
//
// one operation at a time: accept, then per level a read and a capture,
// then a write per level that changes, then the response load; an
// allocate on a full tree ends after the top capture
// after reset a clearing pass sets every word free; no request is taken
// during it
// a response waiting on rsp ready holds back only the next operation's end
module hierarchical_bitmap_id_allocator #(
   parameter int LEVELS    = hba_pkg::LEVELS_DEF,
   parameter int WORD_BITS = hba_pkg::WORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   hba_req_if.sink   req_chan,
   hba_rsp_if.source rsp_chan
);
   import hba_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   hba_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // maps and response register
   hba_datapath #(
      .LEVELS    (LEVELS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_op        (req_chan.op),
      .req_id        (req_chan.id),
      .rsp_valid     (rsp_chan.valid),
      .rsp_result_id (rsp_chan.result_id),
      .rsp_ok        (rsp_chan.ok),
      .rsp_ready     (rsp_chan.ready)
   );

   // one operation in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while an operation is in flight");

   // clearing pass blocks requests
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_chan.ready)
      else $error("request port open during clearing pass");

   // reads and writes never coincide
   a_rd_wr: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en) && !(cmd.clr_step && cmd.rd_en))
      else $error("conflicting memory commands");

endmodule

FILE: verif/hba_checker.sv
`timescale 1ns / 1ps
// checker for the id allocator: watches request and response transfers,
// predicts each response from its own copy of the free maps and compares
// depends on hba_pkg and hba_if
module hba_checker (
   input  logic        clock,
   input  logic        reset,
   hba_req_if.monitor  req_mon,
   hba_rsp_if.monitor  rsp_mon,
   output int          fail_count,
   output int          pending_count
);
   import hba_pkg::*;

   typedef struct {
      logic [ID_W-1:0] result_id;
      logic            ok;
   } rsp_item_type;

   // free maps, set bit means free
   logic [63:0]  top_map;
   logic [63:0]  mid_map [64];
   logic [63:0]  leaf_map [4096];
   rsp_item_type expected_rsp [$];

   function automatic int lowest_free(logic [63:0] w);
      for (int i = 0; i < 64; i++)
         if (w[i]) return i;
      return 0;
   endfunction

   // clear leaf bit, clear parents while words empty
   task automatic take_id(logic [17:0] id);
      leaf_map[id[17:6]][id[5:0]] = 1'b0;
      if (leaf_map[id[17:6]] == '0) begin
         mid_map[id[17:12]][id[11:6]] = 1'b0;
         if (mid_map[id[17:12]] == '0) top_map[id[17:12]] = 1'b0;
      end
   endtask

   // set leaf bit, set parents where the word was empty before
   task automatic give_id(logic [17:0] id);
      logic was_empty;
      was_empty = leaf_map[id[17:6]] == '0;
      leaf_map[id[17:6]][id[5:0]] = 1'b1;
      if (was_empty) begin
         was_empty = mid_map[id[17:12]] == '0;
         mid_map[id[17:12]][id[11:6]] = 1'b1;
         if (was_empty) top_map[id[17:12]] = 1'b1;
      end
   endtask

   task automatic predict_op(op_type op, logic [17:0] id);
      rsp_item_type r;
      logic         is_free;
      int           t, m, l;
      r.result_id = id;
      r.ok = 1'b0;
      is_free = leaf_map[id[17:6]][id[5:0]];
      case (op)
         OP_ALLOC_ANY: begin
            r.result_id = '0;
            if (top_map != '0) begin
               t = lowest_free(top_map);
               m = lowest_free(mid_map[t]);
               l = lowest_free(leaf_map[t * 64 + m]);
               r.result_id = 18'(t * 4096 + m * 64 + l);
               take_id(r.result_id);
               r.ok = 1'b1;
            end
         end
         OP_ALLOC_ID: if (is_free) begin
            take_id(id);
            r.ok = 1'b1;
         end
         OP_FREE: if (!is_free) begin
            give_id(id);
            r.ok = 1'b1;
         end
         default: r.ok = !is_free;
      endcase
      expected_rsp.push_back(r);
   endtask

   // predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         top_map = '1;
         for (int i = 0; i < 64; i++) mid_map[i] = '1;
         for (int i = 0; i < 4096; i++) leaf_map[i] = '1;
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_op(op_type'(req_mon.op), req_mon.id);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response with nothing expected: result_id %0d ok %0b",
                      rsp_mon.result_id, rsp_mon.ok);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_mon.result_id !== e.result_id) begin
                  $error("result_id expected %0d actual %0d", e.result_id,
                         rsp_mon.result_id);
                  fail_count++;
               end
               if (rsp_mon.ok !== e.ok) begin
                  $error("ok expected %0b actual %0b", e.ok, rsp_mon.ok);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsp.size();
   end
endmodule

FILE: verif/hierarchical_bitmap_id_allocator_tb.sv
`timescale 1ns / 1ps
// testbench top for the id allocator: clock, reset, request stimulus,
// response stalls and the verdict
// depends on hba_pkg, hba_if, hba_checker and the allocator rtl
module hierarchical_bitmap_id_allocator_tb;
   import hba_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   logic [17:0] held_ids [$];

   hba_req_if req_chan ();
   hba_rsp_if rsp_chan ();

   hierarchical_bitmap_id_allocator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   hba_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan.monitor),
      .rsp_mon       (rsp_chan.monitor),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response stalls: stall phases of random length, sometimes none
   initial begin
      int mode;
      rsp_chan.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            @(posedge clock);
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // one request transfer; valid stays high when the next follows at once
   task automatic send_op(op_type op, logic [17:0] id);
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.id    <= id;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (op == OP_ALLOC_ID || op == OP_ALLOC_ANY) held_ids.push_back(id);
   endtask

   task automatic gap();
      int n;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (n != 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [17:0] pick_id();
      case ($urandom_range(0, 4))
         0: return 18'($urandom);
         1: return 18'($urandom_range(0, 300));
         2: return 18'($urandom_range(262143 - 200, 262143));
         default: return held_ids.size() != 0 ?
                  held_ids[$urandom_range(0, held_ids.size() - 1)] : 18'($urandom);
      endcase
   endfunction

   initial begin
      op_type op;
      int     burst;
      req_chan.valid = 1'b0;
      req_chan.op = OP_ALLOC_ANY;
      req_chan.id = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, double alloc and double free
      send_op(OP_QUERY, 18'd0);
      send_op(OP_ALLOC_ANY, 18'h3ffff);
      send_op(OP_ALLOC_ANY, 18'd0);
      send_op(OP_QUERY, 18'd0);
      send_op(OP_ALLOC_ID, 18'h3ffff);
      send_op(OP_ALLOC_ID, 18'h3ffff);
      send_op(OP_QUERY, 18'h3ffff);
      send_op(OP_FREE, 18'h3ffff);
      send_op(OP_FREE, 18'h3ffff);
      send_op(OP_FREE, 18'd0);
      send_op(OP_ALLOC_ANY, 18'h2aaaa);
      send_op(OP_ALLOC_ID, 18'h15555);
      send_op(OP_FREE, 18'h15555);
      send_op(OP_QUERY, 18'h15555);
      // fill one leaf word, then free within it to relight the parent bit
      for (int i = 64; i < 128; i++) send_op(OP_ALLOC_ID, 18'(i));
      send_op(OP_FREE, 18'd100);
      send_op(OP_ALLOC_ANY, 18'd0);
      drain();

      // random bursts, biased toward real allocate and free traffic
      for (int n = 0; n < 1500; ) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && n < 1500; b++, n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: op = OP_ALLOC_ANY;
               3, 4:    op = OP_ALLOC_ID;
               5, 6, 7: op = OP_FREE;
               default: op = OP_QUERY;
            endcase
            send_op(op, pick_id());
            gap();
         end
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(0, 20)) @(posedge clock);
         if (n == 700) drain();
      end

      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
